/* src/segment_lcd_serial_writer_top_assert.svh */
// Assertion macros for the segment LCD serial writer checker.
`ifndef SEGMENT_LCD_SERIAL_WRITER_TOP_ASSERT_SVH
`define SEGMENT_LCD_SERIAL_WRITER_TOP_ASSERT_SVH

// Clocked on clk_i, quiet while rst_ni is low.
`define LCDW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LCDW_ASSERT_NEXT(lbl, ante, cons, msg) \
  `LCDW_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* src/lcdw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lcdw_pkg
// Types, constants and lookup tables of the segment LCD serial writer.
// ----------------------------------------------------------------------------
package lcdw_pkg;

  localparam int unsigned NUM_DIGITS     = 17;
  localparam int unsigned ADDR_TABLE_LEN = 17;
  localparam int unsigned POS_LIMIT      = (NUM_DIGITS < ADDR_TABLE_LEN) ?
                                           (NUM_DIGITS - 1) : (ADDR_TABLE_LEN - 1);

  localparam int unsigned FRAME_BITS = 13;
  localparam int unsigned SEQ_BITS   = 2 * FRAME_BITS;
  localparam int unsigned CNT_W      = $clog2(SEQ_BITS + 1);

  localparam logic [2:0] MODE_COMMAND = 3'b100;
  localparam logic [2:0] MODE_DATA    = 3'b101;

  localparam logic [1:0] OP_COMMAND = 2'd0;
  localparam logic [1:0] OP_RAW     = 2'd1;
  localparam logic [1:0] OP_HEX     = 2'd2;
  localparam logic [1:0] OP_SEGMENT = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [4:0] position;
    logic [5:0] address;
    logic [7:0] value;
  } in_t;

  typedef struct packed {
    logic data_bit;
    logic frame_end;
    logic last;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } state_e;

  typedef struct packed {
    logic load;
    logic shift;
  } dp_cmd_t;

  typedef struct packed {
    logic last_bit;
  } dp_status_t;

  function automatic logic [5:0] base_addr(input logic [4:0] p);
    logic [5:0] a;
    case (p)
      5'd0:    a = 6'h22;
      5'd1:    a = 6'h20;
      5'd2:    a = 6'h1e;
      5'd3:    a = 6'h1c;
      5'd4:    a = 6'h1a;
      5'd5:    a = 6'h18;
      5'd6:    a = 6'h16;
      5'd7:    a = 6'h14;
      5'd8:    a = 6'h12;
      5'd9:    a = 6'h10;
      5'd10:   a = 6'h0e;
      5'd11:   a = 6'h0c;
      5'd12:   a = 6'h00;
      5'd13:   a = 6'h02;
      5'd14:   a = 6'h04;
      5'd15:   a = 6'h06;
      default: a = 6'h08;
    endcase
    return a;
  endfunction

  function automatic logic [3:0] font_even(input logic [3:0] d);
    logic [3:0] f;
    case (d)
      4'h0: f = 4'h7;  4'h1: f = 4'h2;  4'h2: f = 4'hb;  4'h3: f = 4'hb;
      4'h4: f = 4'he;  4'h5: f = 4'hd;  4'h6: f = 4'hd;  4'h7: f = 4'h3;
      4'h8: f = 4'hf;  4'h9: f = 4'hf;  4'ha: f = 4'hf;  4'hb: f = 4'hc;
      4'hc: f = 4'h5;  4'hd: f = 4'ha;  4'he: f = 4'hd;
      default: f = 4'hd;
    endcase
    return f;
  endfunction

  function automatic logic [3:0] font_odd(input logic [3:0] d);
    logic [3:0] f;
    case (d)
      4'h0: f = 4'h7;  4'h1: f = 4'h1;  4'h2: f = 4'h6;  4'h3: f = 4'h5;
      4'h4: f = 4'h1;  4'h5: f = 4'h5;  4'h6: f = 4'h7;  4'h7: f = 4'h1;
      4'h8: f = 4'h7;  4'h9: f = 4'h5;  4'ha: f = 4'h3;  4'hb: f = 4'h7;
      4'hc: f = 4'h6;  4'hd: f = 4'h7;  4'he: f = 4'h6;
      default: f = 4'h2;
    endcase
    return f;
  endfunction

  // Mode, address MSB first, nibble LSB first.
  function automatic logic [FRAME_BITS-1:0] write_frame(input logic [5:0] addr,
                                                        input logic [3:0] nib);
    return {MODE_DATA, addr, nib[0], nib[1], nib[2], nib[3]};
  endfunction

endpackage
`default_nettype wire

/* src/lcdw_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lcdw_ctrl
// Controller: takes one request word, then sends its bits until the last.
// ----------------------------------------------------------------------------
module lcdw_ctrl import lcdw_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  state_e state_q, state_d;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_BUSY);
  assign cmd_o.load  = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.shift = (state_q == ST_BUSY) && !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_BUSY;
      end
      ST_BUSY: begin
        if (!out_stall_i && status_i.last_bit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

/* src/lcdw_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lcdw_datapath
// Builds the bit sequence of a request and shifts it out MSB first.
// ----------------------------------------------------------------------------
module lcdw_datapath import lcdw_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire in_t     in_data_i,
  input  wire dp_cmd_t cmd_i,
  output dp_status_t   status_o,
  output out_t         out_data_o
);

  logic [SEQ_BITS-1:0] bits_q, bits_d;
  logic [SEQ_BITS-1:0] fe_q, fe_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;

  logic [4:0]            pos;
  logic [5:0]            base;
  logic [3:0]            ev, od;
  logic [SEQ_BITS-1:0]   seq;
  logic [SEQ_BITS-1:0]   fe;
  logic [CNT_W-1:0]      len;

  always_comb begin
    pos  = (in_data_i.position > 5'(POS_LIMIT)) ? 5'(POS_LIMIT) : in_data_i.position;
    base = base_addr(pos);
    if (in_data_i.op == OP_HEX) begin
      ev = font_even(in_data_i.value[3:0]);
      od = font_odd(in_data_i.value[3:0]);
    end else begin
      // Remap GFEDCBA into the two display nibbles.
      ev = {in_data_i.value[6], in_data_i.value[1], in_data_i.value[5], in_data_i.value[0]};
      od = {1'b0, in_data_i.value[3], in_data_i.value[2], in_data_i.value[4]};
    end

    seq = '0;
    fe  = '0;
    case (in_data_i.op)
      OP_COMMAND: begin
        seq = {MODE_COMMAND, in_data_i.value, 1'b1, (SEQ_BITS - 12)'(0)};
        fe[SEQ_BITS-12] = 1'b1;
        len = CNT_W'(12);
      end
      OP_RAW: begin
        seq = {write_frame(in_data_i.address, in_data_i.value[3:0]),
               (SEQ_BITS - FRAME_BITS)'(0)};
        fe[SEQ_BITS-FRAME_BITS] = 1'b1;
        len = CNT_W'(FRAME_BITS);
      end
      default: begin
        seq = {write_frame(base, ev), write_frame(base + 6'd1, od)};
        fe[SEQ_BITS-FRAME_BITS] = 1'b1;
        fe[0] = 1'b1;
        len = CNT_W'(SEQ_BITS);
      end
    endcase
  end

  always_comb begin
    bits_d = bits_q;
    fe_d   = fe_q;
    cnt_d  = cnt_q;
    if (cmd_i.load) begin
      bits_d = seq;
      fe_d   = fe;
      cnt_d  = len;
    end else if (cmd_i.shift) begin
      // Advance to the next bit.
      bits_d = {bits_q[SEQ_BITS-2:0], 1'b0};
      fe_d   = {fe_q[SEQ_BITS-2:0], 1'b0};
      cnt_d  = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
    fe_q   <= fe_d;
  end

  assign status_o.last_bit    = (cnt_q == CNT_W'(1));
  assign out_data_o.data_bit  = bits_q[SEQ_BITS-1];
  assign out_data_o.frame_end = fe_q[SEQ_BITS-1];
  assign out_data_o.last      = (cnt_q == CNT_W'(1));

endmodule
`default_nettype wire

/* src/segment_lcd_serial_writer_top.sv */
// The first bit of a request is offered in the cycle after its word is taken.
// One bit per cycle leaves the shift register while the output does not stall;
// a command has 12 bits, a raw write 13 and a show 26. A new word is loaded only
// in idle, after the last bit. Output stalls stretch an item by the stalled cycles.
// Reset: asynchronous, active low; the controller returns to idle.
`default_nettype none
// ----------------------------------------------------------------------------
// segment_lcd_serial_writer_top
// Serializes command and display writes for a three-wire segment LCD driver.
// ----------------------------------------------------------------------------
module segment_lcd_serial_writer_top import lcdw_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  lcdw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lcdw_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire

/* src/lcdw_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lcdw_checker
// Port-level checks of the segment LCD serial writer.
// ----------------------------------------------------------------------------
`include "segment_lcd_serial_writer_top_assert.svh"

module lcdw_checker import lcdw_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire in_t  in_data_i,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire out_t out_data_o
);

  // A stalled bit holds.
  `LCDW_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                    out_valid_o && $stable(out_data_o), "stalled bit word changed")
  // No new word while bits of the previous one are pending.
  `LCDW_ASSERT(a_one_at_a_time, (in_valid_i && !in_stall_o) |-> !out_valid_o,
               "accept while busy")
  // Every item opens with a 1 and is longer than one bit.
  `LCDW_ASSERT_NEXT(a_first_bit, in_valid_i && !in_stall_o,
                    out_valid_o && out_data_o.data_bit && !out_data_o.last,
                    "bad first bit after accept")
  // The last bit closes a frame and ends the item.
  `LCDW_ASSERT_NEXT(a_last_done, out_valid_o && !out_stall_i && out_data_o.last,
                    !out_valid_o, "bits continue after last")

endmodule

bind segment_lcd_serial_writer_top lcdw_checker u_lcdw_checker (.*);
`default_nettype wire

/* tb/segment_lcd_serial_writer_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_lcd_serial_writer_checker
// Watches both word channels of the serial writer. For every request taken
// on the input side it builds the serial bit sequence the controller should
// see, then compares each bit word leaving the block with the oldest one.
// ----------------------------------------------------------------------------
module segment_lcd_serial_writer_checker import lcdw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  out_t out_data_i,
  output int   errors_o,
  output int   pending_o,
  output int   checked_o
);

  // Entry i sits at bits [4*i +: 4]; digit 15 leftmost.
  localparam logic [63:0] EVEN_NIBBLE_FONT = 64'hd_d_a_5_c_f_f_f_3_d_d_e_b_b_2_7;
  localparam logic [63:0] ODD_NIBBLE_FONT  = 64'h2_6_7_6_7_3_5_7_1_7_5_1_5_6_1_7;
  // Digit base address, entry i at bits [8*i +: 6]; position 16 leftmost.
  localparam logic [135:0] DIGIT_BASE =
    136'h08_06_04_02_00_0c_0e_10_12_14_16_18_1a_1c_1e_20_22;

  out_t expected_bits[$];
  out_t want;
  int   mismatch_count = 0;
  int   checked_count  = 0;

  assign errors_o  = mismatch_count;
  assign checked_o = checked_count;

  function automatic void push_bit(input logic level, input logic release_cs);
    out_t w;
    w.data_bit  = level;
    w.frame_end = release_cs;
    w.last      = 1'b0;
    expected_bits.push_back(w);
  endfunction

  function automatic void push_msb_first(input logic [7:0] bits, input int n);
    for (int i = n - 1; i >= 0; i--) push_bit(bits[i], 1'b0);
  endfunction

  function automatic void push_write_frame(input logic [5:0] addr, input logic [3:0] nib);
    push_msb_first({5'd0, MODE_DATA}, 3);
    push_msb_first({2'd0, addr}, 6);
    for (int i = 0; i < 4; i++) push_bit(nib[i], i == 3);
  endfunction

  function automatic void serialize_request(input in_t req);
    int unsigned pos;
    logic [5:0]  base;
    logic [3:0]  even_nib;
    logic [3:0]  odd_nib;
    out_t        tail;
    if (req.op == OP_COMMAND) begin
      push_msb_first({5'd0, MODE_COMMAND}, 3);
      push_msb_first(req.value, 8);
      push_bit(1'b1, 1'b1);
    end else if (req.op == OP_RAW) begin
      push_write_frame(req.address, req.value[3:0]);
    end else begin
      // Clamp to the last digit and to the end of the address table.
      pos = req.position;
      if (pos > NUM_DIGITS - 1) pos = NUM_DIGITS - 1;
      if (pos > ADDR_TABLE_LEN - 1) pos = ADDR_TABLE_LEN - 1;
      base = DIGIT_BASE[pos*8 +: 6];
      if (req.op == OP_HEX) begin
        even_nib = EVEN_NIBBLE_FONT[req.value[3:0]*4 +: 4];
        odd_nib  = ODD_NIBBLE_FONT[req.value[3:0]*4 +: 4];
      end else begin
        // Remap GFEDCBA onto the two display nibbles; bit seven drops out.
        even_nib = {req.value[6], req.value[1], req.value[5], req.value[0]};
        odd_nib  = {1'b0, req.value[3], req.value[2], req.value[4]};
      end
      push_write_frame(base, even_nib);
      push_write_frame(base + 6'd1, odd_nib);
    end
    tail = expected_bits.pop_back();
    tail.last = 1'b1;
    expected_bits.push_back(tail);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) serialize_request(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_bits.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected bit word: expected none, ", $time,
                   "got data_bit=%b frame_end=%b last=%b",
                   out_data_i.data_bit, out_data_i.frame_end, out_data_i.last);
        end else begin
          want = expected_bits.pop_front();
          checked_count++;
          if (out_data_i !== want) begin
            mismatch_count++;
            $display("%0t: bit %0d mismatch: ", $time, checked_count,
                     "expected data_bit=%b frame_end=%b last=%b, ",
                     want.data_bit, want.frame_end, want.last,
                     "got data_bit=%b frame_end=%b last=%b",
                     out_data_i.data_bit, out_data_i.frame_end, out_data_i.last);
          end
        end
      end
    end
    pending_o <= expected_bits.size();
  end

endmodule

/* tb/segment_lcd_serial_writer_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_lcd_serial_writer_top_tb
// Drives display requests into the serial writer: a directed set covering
// every operation, field extremes and position clamping, then random ones,
// with random gaps on the input and random stalls on the bit output.
// ----------------------------------------------------------------------------
module segment_lcd_serial_writer_top_tb import lcdw_pkg::*; ();

  localparam int RANDOM_ITEMS = 240;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  int errors;
  int pending;
  int checked;
  int op_count [4];
  int sent_count;
  int free_len;
  int stall_len;

  segment_lcd_serial_writer_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  segment_lcd_serial_writer_checker checker_inst (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic in_t build_request(input logic [1:0] op, input logic [4:0] pos,
                                        input logic [5:0] addr, input logic [7:0] val);
    in_t r;
    r.op       = op;
    r.position = pos;
    r.address  = addr;
    r.value    = val;
    return r;
  endfunction

  function automatic in_t random_request();
    in_t r;
    r.op = 2'($urandom_range(0, 3));
    // Mostly valid digit positions, some beyond the last digit.
    r.position = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, 16))
                                               : 5'($urandom_range(17, 31));
    r.address  = 6'($urandom);
    r.value    = 8'($urandom);
    return r;
  endfunction

  // Present a word and hold it until taken.
  task automatic send_word(input in_t w);
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    op_count[w.op]++;
    sent_count++;
  endtask

  task automatic pause_sender();
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Receiver: free runs, mostly short, now and then a long one; stalls likewise.
  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      free_len  = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(30, 120);
      stall_len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 30);
      out_stall <= 1'b0;
      repeat (free_len) @(posedge clk);
      out_stall <= 1'b1;
      repeat (stall_len) @(posedge clk);
    end
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    sent_count = 0;
    for (int i = 0; i < 4; i++) op_count[i] = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: command extremes, unused fields random or at their extremes.
    send_word(build_request(OP_COMMAND, 5'($urandom), 6'($urandom), 8'h00)); pause_sender();
    send_word(build_request(OP_COMMAND, 5'($urandom), 6'($urandom), 8'hff)); pause_sender();
    send_word(build_request(OP_COMMAND, 5'd31, 6'd63, 8'ha5));               pause_sender();
    // Raw writes: address extremes, wide data nibble.
    send_word(build_request(OP_RAW, 5'($urandom), 6'd0, 8'h00));  pause_sender();
    send_word(build_request(OP_RAW, 5'($urandom), 6'd63, 8'hff)); pause_sender();
    send_word(build_request(OP_RAW, 5'd31, 6'h2a, 8'hf5));        pause_sender();
    send_word(build_request(OP_RAW, 5'd0, 6'h15, 8'h0a));         pause_sender();
    // Hex digits: first and last position, clamped positions, wide digit.
    send_word(build_request(OP_HEX, 5'd0, 6'($urandom), 8'h00));  pause_sender();
    send_word(build_request(OP_HEX, 5'd16, 6'($urandom), 8'h0f)); pause_sender();
    send_word(build_request(OP_HEX, 5'd17, 6'($urandom), 8'h08)); pause_sender();
    send_word(build_request(OP_HEX, 5'd31, 6'd63, 8'hf1));        pause_sender();
    send_word(build_request(OP_HEX, 5'd12, 6'($urandom), 8'h5a)); pause_sender();
    send_word(build_request(OP_HEX, 5'd11, 6'($urandom), 8'h0b)); pause_sender();
    // Segment patterns: all segments, bit seven alone, full byte, clamped.
    send_word(build_request(OP_SEGMENT, 5'd12, 6'($urandom), 8'h7f)); pause_sender();
    send_word(build_request(OP_SEGMENT, 5'd0, 6'($urandom), 8'h80));  pause_sender();
    send_word(build_request(OP_SEGMENT, 5'd5, 6'($urandom), 8'hff));  pause_sender();
    send_word(build_request(OP_SEGMENT, 5'd20, 6'd63, 8'h55));        pause_sender();
    send_word(build_request(OP_SEGMENT, 5'd16, 6'($urandom), 8'h2a)); pause_sender();
    send_word(build_request(OP_SEGMENT, 5'd31, 6'd0, 8'h00));         pause_sender();

    // Random part, with a calm stretch of back-to-back words every 64.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_word(random_request());
      if ((i % 64) >= 16) pause_sender();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d commands, %0d raw writes, ",
             sent_count, op_count[OP_COMMAND], op_count[OP_RAW],
             "%0d hex digits, %0d segment patterns",
             op_count[OP_HEX], op_count[OP_SEGMENT]);
    $display("Checked %0d serial bit words under random input gaps and output stalls", checked);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/lcdw_pkg.sv
src/lcdw_ctrl.sv
src/lcdw_datapath.sv
src/segment_lcd_serial_writer_top.sv
src/lcdw_checker.sv
tb/segment_lcd_serial_writer_checker.sv
tb/segment_lcd_serial_writer_top_tb.sv
